>>> rtl/serial_command_pwm_fade_ramp_assert.svh
// assertion macros for the serial command pwm fade ramp block
// used by the port checker, no other dependencies
`ifndef SERIAL_COMMAND_PWM_FADE_RAMP_ASSERT_SVH
`define SERIAL_COMMAND_PWM_FADE_RAMP_ASSERT_SVH

// same-cycle implication, quiet while reset is low
`define SCPFR_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scpfr: same-cycle check failed");

// next-cycle implication, quiet while reset is low
`define SCPFR_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scpfr: next-cycle check failed");

`endif

>>> rtl/scpfr_pkg.sv
// shared types and constants for the serial command pwm fade ramp block
// no dependencies
package scpfr_pkg;

	localparam int VALUE_BITS_DEF = 16;
	localparam int DUTY_BITS      = 16;
	localparam int WAIT_BITS      = 26;
	localparam int MS_PER_S       = 1000;
	localparam int MS_BITS        = 10;   // bits needed for the ms-per-second factor
	localparam int QUEUE_DEPTH    = 2;    // power of two

	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] RADIX    = 8'd10;

	localparam logic [1:0] FIELD_START  = 2'd0;
	localparam logic [1:0] FIELD_TARGET = 2'd1;
	localparam logic [1:0] FIELD_SECS   = 2'd2;
	localparam logic [1:0] FIELD_PAST   = 2'd3;

	// class of an item as seen by the front end
	typedef enum logic [2:0] {
		K_TICK,
		K_CR,
		K_SPACE,
		K_DIGIT,
		K_OTHER
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] digit;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> rtl/scpfr_front.sv
// front end: accepts items and classifies them into tick, return, space, digit or other
// depends on scpfr_pkg
module scpfr_front import scpfr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      cmd,
	input  logic [7:0] rx_byte,
	input  q_status_t q_status,
	output logic      push,
	output item_t     push_item
);

	logic  held_q;
	item_t item_q;
	item_t item_d;
	logic  accept;

	assign in_stall  = held_q && q_status.full;
	assign accept    = in_valid && !in_stall;
	assign push      = held_q && !q_status.full;
	assign push_item = item_q;

	always_comb begin
		item_d.digit = 4'(rx_byte - CH_ZERO);
		if (cmd) begin
			item_d.kind = K_TICK;
		end else if (rx_byte == CH_CR) begin
			item_d.kind = K_CR;
		end else if (rx_byte == CH_SPACE) begin
			item_d.kind = K_SPACE;
		end else if (rx_byte >= CH_ZERO && rx_byte < CH_ZERO + RADIX) begin
			item_d.kind = K_DIGIT;
		end else begin
			item_d.kind = K_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
		end else if (accept) begin
			held_q <= 1'b1;
		end else if (push) begin
			held_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item_d;
		end
	end

endmodule

>>> rtl/scpfr_queue.sv
// short queue of classified items between front and back end
// depends on scpfr_pkg
module scpfr_queue import scpfr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  item_t     push_item,
	input  logic      pop,
	output item_t     head,
	output q_status_t status
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	item_t         slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign head         = slot_q[rd_ptr_q];
	assign status.full  = (count_q == NW'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/scpfr_back.sv
// back end: command parser, ramp sequencer, restoring divider and result register
// depends on scpfr_pkg
module scpfr_back import scpfr_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  item_t                head,
	input  q_status_t            q_status,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DUTY_BITS-1:0] duty,
	output logic                 duty_written,
	output logic                 busy_res,
	output logic                 dropped
);

	localparam int VB = VALUE_BITS;
	localparam int DW = VB + MS_BITS;
	localparam int CW = $clog2(DW + 1);
	localparam int QW = (DW > WAIT_BITS) ? DW : WAIT_BITS;
	localparam logic [WAIT_BITS-1:0] WAIT_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t               state_q;
	logic [VB-1:0]        start_acc_q, target_acc_q, secs_acc_q;
	logic [1:0]           field_q;
	logic [VB-1:0]        cur_q, tgt_q;
	logic [WAIT_BITS-1:0] period_q, wait_q;
	logic                 ramping_q, down_q;
	logic                 out_valid_q, written_q, dropped_q;
	logic [CW-1:0]        cnt_q;
	logic [DW-1:0]        div_q;
	logic [VB-1:0]        rem_q, diff_q;

	logic                 out_free;
	logic                 starts_div;
	logic                 pop_written;
	logic                 pop_dropped;
	logic [VB-1:0]        acc_sel;
	logic [VB+3:0]        acc_sum;
	logic [VB-1:0]        acc_new;
	logic [VB:0]          trial;
	logic                 qbit;
	logic [QW-1:0]        quot_ext;
	logic [WAIT_BITS-1:0] period_new;

	assign out_free   = !out_valid_q || !out_stall;
	assign pop        = (state_q == ST_IDLE) && !q_status.empty && out_free;
	assign starts_div = pop && (head.kind == K_CR) && !ramping_q
		&& (start_acc_q != target_acc_q);

	// flags of the result for the item being popped
	assign pop_dropped = (head.kind != K_TICK) && ramping_q;
	assign pop_written = (head.kind == K_TICK)
		? (ramping_q && (wait_q <= WAIT_BITS'(1)) && (cur_q != tgt_q))
		: ((head.kind == K_CR) && !ramping_q && (start_acc_q == target_acc_q));

	assign out_valid    = out_valid_q;
	assign duty         = DUTY_BITS'(cur_q);
	assign duty_written = written_q;
	assign busy_res     = ramping_q;
	assign dropped      = dropped_q;

	// decimal digit into the field being parsed, saturating
	always_comb begin
		case (field_q)
			FIELD_START:  acc_sel = start_acc_q;
			FIELD_TARGET: acc_sel = target_acc_q;
			default:      acc_sel = secs_acc_q;
		endcase
		acc_sum = (VB+4)'({acc_sel, 3'b000}) + (VB+4)'({acc_sel, 1'b0})
			+ (VB+4)'(head.digit);
		acc_new = (|acc_sum[VB+3:VB]) ? '1 : acc_sum[VB-1:0];
	end

	// one quotient bit per cycle
	assign trial = {rem_q, div_q[DW-1]};
	assign qbit  = (trial >= {1'b0, diff_q});

	// step period clamped to one tick at least and to the wait counter range
	always_comb begin
		quot_ext = QW'(div_q);
		if (quot_ext > QW'(WAIT_MAX)) begin
			period_new = WAIT_MAX;
		end else if (quot_ext == '0) begin
			period_new = WAIT_BITS'(1);
		end else begin
			period_new = quot_ext[WAIT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			start_acc_q  <= '0;
			target_acc_q <= '0;
			secs_acc_q   <= '0;
			field_q      <= FIELD_START;
			cur_q        <= '0;
			tgt_q        <= '0;
			period_q     <= '0;
			wait_q       <= '0;
			ramping_q    <= 1'b0;
			down_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			written_q    <= 1'b0;
			dropped_q    <= 1'b0;
			cnt_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						out_valid_q <= !starts_div;
						written_q   <= pop_written;
						dropped_q   <= pop_dropped;
						if (head.kind == K_TICK) begin
							if (ramping_q) begin
								if (wait_q > WAIT_BITS'(1)) begin
									wait_q <= wait_q - WAIT_BITS'(1);
								end else if (cur_q == tgt_q) begin
									wait_q    <= '0;
									ramping_q <= 1'b0;
								end else begin
									cur_q     <= down_q ? cur_q - VB'(1) : cur_q + VB'(1);
									wait_q    <= period_q;
								end
							end
						end else if (!ramping_q) begin
							unique case (head.kind)
								K_CR: begin
									cur_q        <= start_acc_q;
									tgt_q        <= target_acc_q;
									start_acc_q  <= '0;
									target_acc_q <= '0;
									secs_acc_q   <= '0;
									field_q      <= FIELD_START;
									if (starts_div) begin
										down_q  <= start_acc_q > target_acc_q;
										cnt_q   <= CW'(DW);
										state_q <= ST_DIV;
									end
								end
								K_SPACE: begin
									if (field_q != FIELD_PAST) begin
										field_q <= field_q + 2'd1;
									end
								end
								K_DIGIT: begin
									unique case (field_q)
										FIELD_START:  start_acc_q  <= acc_new;
										FIELD_TARGET: target_acc_q <= acc_new;
										FIELD_SECS:   secs_acc_q   <= acc_new;
										default:      ;
									endcase
								end
								default: ;
							endcase
						end
					end else if (!out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					period_q    <= period_new;
					wait_q      <= period_new;
					ramping_q   <= 1'b1;
					out_valid_q <= 1'b1;
					written_q   <= 1'b1;
					dropped_q   <= 1'b0;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// divider datapath: dividend shifts out as the quotient shifts in
	always_ff @(posedge clk) begin
		if (starts_div) begin
			div_q  <= DW'(secs_acc_q) * DW'(MS_PER_S);
			rem_q  <= '0;
			diff_q <= (start_acc_q > target_acc_q) ? start_acc_q - target_acc_q
				: target_acc_q - start_acc_q;
		end else if (state_q == ST_DIV) begin
			div_q <= {div_q[DW-2:0], qbit};
			rem_q <= qbit ? VB'(trial - {1'b0, diff_q}) : trial[VB-1:0];
		end
	end

endmodule

>>> rtl/serial_command_pwm_fade_ramp.sv
// an accepted byte or tick is registered in the front end, written into the queue and, once popped,
// gives its result registered; a ramp line gives it after the restoring divider (one bit a cycle)
// throughput: one item a cycle when not stalled; the queue takes items until full while dividing
// reset: arst_n low clears the parser, the duty, the ramp and the queue at once
// depends on scpfr_pkg, scpfr_front, scpfr_queue, scpfr_back
module serial_command_pwm_fade_ramp import scpfr_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel: serial byte or millisecond tick
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cmd,
	input  logic [7:0]           rx_byte,
	// result channel: one result per item
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DUTY_BITS-1:0] duty,
	output logic                 duty_written,
	output logic                 busy_res,
	output logic                 dropped
);

	// classified item handed from the front end to the queue
	logic      push;
	item_t     push_item;
	// head of the queue for the back end and its fill state, seen by both ends
	item_t     head;
	q_status_t q_status;
	logic      pop;

	// front end: registers each accepted item together with its class,
	// so the back end never decodes characters itself
	scpfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.rx_byte   (rx_byte),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	// short queue so the front keeps taking items, until it is full, while the back is dividing
	// or its result is held by a stalled receiver
	scpfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	// back end: owns the parser accumulators, the ramp state and the divider
	// that turns seconds and duty span into a step period; drops bytes while ramping
	scpfr_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.duty         (duty),
		.duty_written (duty_written),
		.busy_res     (busy_res),
		.dropped      (dropped)
	);

endmodule

>>> rtl/scpfr_checker.sv
// port-level checker for the serial command pwm fade ramp block, bound to the top level
// depends on scpfr_pkg and serial_command_pwm_fade_ramp_assert.svh
`include "serial_command_pwm_fade_ramp_assert.svh"

module scpfr_checker import scpfr_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [DUTY_BITS-1:0] duty,
	input logic                 duty_written,
	input logic                 busy_res,
	input logic                 dropped
);

	// a discarded byte only happens mid-ramp and never touches the duty
	`SCPFR_ASSERT_IMP(a_drop_busy, clk, arst_n, out_valid && dropped, busy_res)
	`SCPFR_ASSERT_IMP(a_drop_nowrite, clk, arst_n, out_valid && dropped, !duty_written)
	// a held result keeps its duty
	`SCPFR_ASSERT_NXT(a_hold_duty, clk, arst_n, out_valid && out_stall, out_valid && $stable(duty))

endmodule

bind serial_command_pwm_fade_ramp scpfr_checker u_scpfr_checker (.*);

>>> tb/sv/serial_command_pwm_fade_ramp_test.sv
// testbench for serial_command_pwm_fade_ramp: command lines and millisecond ticks in, duty reports out
// an in-bench predictor of the line parser, step divider and ramp timer checks every report
// depends on scpfr_pkg and the serial_command_pwm_fade_ramp rtl
module serial_command_pwm_fade_ramp_test;
	timeunit 1ns;
	timeprecision 1ps;

	import scpfr_pkg::*;

	// meaning of the cmd input
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam int              ACC_BITS  = VALUE_BITS_DEF;
	localparam longint unsigned ACC_TOP   = (64'd1 << ACC_BITS) - 1;
	localparam longint unsigned WAIT_TOP  = (64'd1 << WAIT_BITS) - 1;

	// receiver hold-off long enough to fill the block and stall its input
	localparam int HOLD_CYCLES   = 300;
	// longest legitimate quiet stretch is the hold-off plus a divider pass, taken ten times over
	localparam int QUIET_LIMIT   = 10 * (HOLD_CYCLES + VALUE_BITS_DEF + 14);
	// drain time at the end, twice the slowest latency of the block
	localparam int SETTLE_CYCLES = 2 * (VALUE_BITS_DEF + 14);
	localparam int ITEM_TARGET   = 1200;
	// loose bytes may only build ramps this short, counted in ticks
	localparam longint unsigned LOOSE_RAMP_MAX = 200;

	typedef struct packed {
		logic [DUTY_BITS-1:0] duty;
		logic                 written;
		logic                 busy;
		logic                 drop;
	} duty_report_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 cmd;
	logic [7:0]           rx_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [DUTY_BITS-1:0] duty;
	logic                 duty_written;
	logic                 busy_res;
	logic                 dropped;

	serial_command_pwm_fade_ramp #(
		.VALUE_BITS(ACC_BITS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.duty         (duty),
		.duty_written (duty_written),
		.busy_res     (busy_res),
		.dropped      (dropped)
	);

	// predicted state of the block
	logic [ACC_BITS-1:0]  line_start, line_target, line_secs;
	logic [1:0]           line_field;
	logic [ACC_BITS-1:0]  cur_duty, goal_duty;
	logic [WAIT_BITS-1:0] step_ticks, ticks_left;
	logic                 ramp_on, ramp_down;

	duty_report_t due_duty_reports[$];
	int           mismatches;
	int unsigned  effective_items;
	int           burst_left;
	bit           feed_steady;
	bit           hold_ask;
	int           quiet_cycles;
	int           stall_mode;
	int           stall_span;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint unsigned acc_push(longint unsigned acc, longint unsigned d);
		longint unsigned v;
		v = acc * RADIX + d;
		return (v > ACC_TOP) ? ACC_TOP : v;
	endfunction

	// ticks waited after every written value, clamped to one tick and to the counter width
	function automatic longint unsigned ticks_per_step(longint unsigned s, longint unsigned t,
			longint unsigned sec);
		longint unsigned span;
		longint unsigned per;
		span = (s > t) ? s - t : t - s;
		per  = (sec * MS_PER_S) / span;
		if (per < 1) per = 1;
		if (per > WAIT_TOP) per = WAIT_TOP;
		return per;
	endfunction

	// ticks a line with these fields would keep the block ramping
	function automatic longint unsigned ramp_ticks(longint unsigned s, longint unsigned t,
			longint unsigned sec);
		longint unsigned span;
		if (s == t) return 0;
		span = (s > t) ? s - t : t - s;
		return (span + 1) * ticks_per_step(s, t, sec);
	endfunction

	function automatic void clear_line();
		line_start  = '0;
		line_target = '0;
		line_secs   = '0;
		line_field  = FIELD_START;
	endfunction

	// advance the predicted state by one accepted item and give the report it causes
	task automatic predict_fade_step(input logic c, input logic [7:0] b,
			output duty_report_t r);
		logic [3:0] digit;
		r.written = 1'b0;
		r.drop    = 1'b0;
		if (c == CMD_TICK) begin
			if (ramp_on) begin
				if (ticks_left > 1) begin
					ticks_left = ticks_left - WAIT_BITS'(1);
				end else if (cur_duty == goal_duty) begin
					// wait after the target value has run out
					ticks_left = '0;
					ramp_on    = 1'b0;
				end else begin
					cur_duty   = ramp_down ? cur_duty - 1'b1 : cur_duty + 1'b1;
					r.written  = 1'b1;
					ticks_left = step_ticks;
				end
			end
		end else if (ramp_on) begin
			// every byte is thrown away while ramping, parser untouched
			r.drop = 1'b1;
		end else if (b == CH_CR) begin
			cur_duty  = line_start;
			goal_duty = line_target;
			if (line_start != line_target) begin
				ramp_down  = line_start > line_target;
				step_ticks = WAIT_BITS'(ticks_per_step(line_start, line_target, line_secs));
				ticks_left = step_ticks;
				ramp_on    = 1'b1;
			end
			clear_line();
			r.written = 1'b1;
		end else if (b == CH_SPACE) begin
			if (line_field != FIELD_PAST) line_field = line_field + 1'b1;
		end else if (b >= CH_ZERO && b < CH_ZERO + RADIX) begin
			digit = 4'(b - CH_ZERO);
			case (line_field)
				FIELD_START:  line_start  = ACC_BITS'(acc_push(line_start, digit));
				FIELD_TARGET: line_target = ACC_BITS'(acc_push(line_target, digit));
				FIELD_SECS:   line_secs   = ACC_BITS'(acc_push(line_secs, digit));
				default: ;
			endcase
		end
		r.duty = cur_duty[DUTY_BITS-1:0];
		r.busy = ramp_on;
	endtask

	// ---------------------------------------------------------------- result checker

	always @(posedge clk) begin : check_report
		duty_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_duty_reports.size() == 0) begin
				mismatches++;
				$display("%0t: report with no item pending: expected none, actual duty %0d",
					$time, duty);
			end else begin
				want = due_duty_reports.pop_front();
				if (duty !== want.duty) begin
					mismatches++;
					$display("%0t: duty expected %0d actual %0d", $time, want.duty, duty);
				end
				if (duty_written !== want.written) begin
					mismatches++;
					$display("%0t: duty_written expected %0b actual %0b", $time,
						want.written, duty_written);
				end
				if (busy_res !== want.busy) begin
					mismatches++;
					$display("%0t: busy_res expected %0b actual %0b", $time, want.busy, busy_res);
				end
				if (dropped !== want.drop) begin
					mismatches++;
					$display("%0t: dropped expected %0b actual %0b", $time, want.drop, dropped);
				end
			end
		end
	end

	// watchdog: too long with nothing moving on either channel ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// stall pattern changes mode every so often; a hold request parks it high for a long stretch
	initial begin
		out_stall  = 1'b0;
		stall_span = 0;
		stall_mode = 0;
		forever begin
			@(negedge clk);
			if (hold_ask) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_ask = 1'b0;
			end else begin
				if (stall_span == 0) begin
					stall_mode = $urandom_range(0, 3);
					stall_span = $urandom_range(20, 200);
				end
				stall_span--;
				case (stall_mode)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 3) == 0);
					2: out_stall = ($urandom_range(0, 3) != 0);
					default: out_stall = ~out_stall;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- sender

	// offer one item, in bursts with random gaps, and log its prediction once accepted
	task automatic send_item(input logic c, input logic [7:0] b);
		duty_report_t r;
		int           gap;
		if (burst_left == 0) begin
			gap = feed_steady ? 0 : $urandom_range(0, 6);
			repeat (gap) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
			burst_left = $urandom_range(1, 16);
		end
		@(negedge clk);
		in_valid = 1'b1;
		cmd      = c;
		rx_byte  = b;
		do @(posedge clk); while (in_stall);
		predict_fade_step(c, b, r);
		due_duty_reports.push_back(r);
		effective_items++;
		burst_left--;
	endtask

	// valid stays up after an accepted item, so drop it before any wait
	task automatic drop_valid();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_reports_done();
		drop_valid();
		while (due_duty_reports.size() != 0) @(posedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_item(CMD_BYTE, s[i]);
	endtask

	function automatic logic [7:0] other_char();
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255));
		while (b == CH_CR || b == CH_SPACE || (b >= CH_ZERO && b < CH_ZERO + RADIX));
		return b;
	endfunction

	function automatic int unsigned pick_duty();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 32'(ACC_TOP);
			default: return $urandom_range(0, 32'(ACC_TOP));
		endcase
	endfunction

	// ticks until the predicted ramp is over, with stray bytes that must be dropped
	task automatic tick_until_settled();
		while (ramp_on) begin
			if ($urandom_range(0, 4) == 0) send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
			else send_item(CMD_TICK, 8'($urandom_range(0, 255)));
		end
	endtask

	// a byte of noise or of a broken line; digits that would build a long ramp are swapped
	task automatic send_loose_byte(input logic [7:0] b);
		longint unsigned d, s, t, sec;
		if (!ramp_on && b >= CH_ZERO && b < CH_ZERO + RADIX) begin
			d   = b - CH_ZERO;
			s   = line_start;
			t   = line_target;
			sec = line_secs;
			case (line_field)
				FIELD_START:  s   = acc_push(s, d);
				FIELD_TARGET: t   = acc_push(t, d);
				FIELD_SECS:   sec = acc_push(sec, d);
				default: ;
			endcase
			if (ramp_ticks(s, t, sec) > LOOSE_RAMP_MAX) b = other_char();
		end
		send_item(CMD_BYTE, b);
	endtask

	// one command line with random content; broken lines stop short and get no carriage return
	task automatic send_command_line(input bit broken);
		int unsigned kind, s, t, sec, span, cut;
		string       txt;
		logic [7:0]  line_bytes[$];
		bit          sprinkle;
		kind = $urandom_range(0, 4);
		case (kind)
			0: begin
				// start equals target, duty set at once
				s   = pick_duty();
				sec = $urandom_range(0, 32'(ACC_TOP));
				txt = $sformatf("%0d %0d %0d", s, s, sec);
			end
			1, 4: begin
				// short ramp at one tick a step, seconds zero or missing
				span = $urandom_range(1, 12);
				s    = pick_duty();
				if (s >= span && (s + span > ACC_TOP || $urandom_range(0, 1) == 1)) t = s - span;
				else t = s + span;
				if (kind == 4)
					txt = $sformatf("%0d %0d 0 %0d %0d", s, t, $urandom_range(0, 999999),
						$urandom_range(0, 999999));
				else if ($urandom_range(0, 1) == 1)
					txt = $sformatf("%0d %0d", s, t);
				else
					txt = $sformatf("%0d %0d 0", s, t);
			end
			2: begin
				// missing or empty fields count as zero
				s = $urandom_range(0, 12);
				case ($urandom_range(0, 4))
					0: txt = "";
					1: txt = $sformatf("%0d", s);
					2: txt = $sformatf("%0d ", s);
					3: txt = $sformatf(" %0d", s);
					default: txt = $sformatf(" %0d  %0d", s, $urandom_range(0, 999999));
				endcase
			end
			default: begin
				// every field at or past the top, so both duties end at the same top value
				s   = $urandom_range(32'(ACC_TOP), 999999);
				t   = $urandom_range(32'(ACC_TOP), 999999);
				sec = $urandom_range(32'(ACC_TOP), 999999);
				txt = $sformatf("%0d %0d %0d", s, t, sec);
			end
		endcase
		if ($urandom_range(0, 5) == 0) txt = {"00", txt};
		sprinkle = ($urandom_range(0, 2) == 0);
		for (int i = 0; i < txt.len(); i++) begin
			if (sprinkle && $urandom_range(0, 7) == 0) line_bytes.push_back(other_char());
			line_bytes.push_back(txt[i]);
		end
		if (broken) begin
			cut = $urandom_range(0, line_bytes.size());
			for (int i = 0; i < cut; i++) send_loose_byte(line_bytes[i]);
		end else begin
			// leftovers of earlier noise would merge into this line, so close them first
			if (line_field != FIELD_START || line_start != 0 || line_target != 0 || line_secs != 0)
			begin
				send_item(CMD_BYTE, CH_CR);
				tick_until_settled();
			end
			foreach (line_bytes[i]) send_item(CMD_BYTE, line_bytes[i]);
			send_item(CMD_BYTE, CH_CR);
		end
		tick_until_settled();
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 2) == 0) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
			else send_loose_byte(8'($urandom_range(0, 255)));
		end
		tick_until_settled();
	endtask

	// ---------------------------------------------------------------- tests

	// tick with no ramp changes nothing, an empty line sets the duty to zero
	task automatic test_idle_and_empty_line();
		send_item(CMD_TICK, 8'($urandom_range(0, 255)));
		send_item(CMD_BYTE, CH_CR);
	endtask

	// start past the top saturates to the target at the top, so the duty is set at once
	task automatic test_saturated_set();
		send_text("66000 65535");
		send_item(CMD_BYTE, CH_CR);
	endtask

	// one step down with seconds zero, so the wait is clamped to a single tick;
	// stray characters and a surplus field on the line, bytes and a carriage return dropped
	task automatic test_short_ramp_with_drops();
		send_text("1 0z 0 9");
		send_item(CMD_BYTE, 8'hFF);
		send_item(CMD_BYTE, CH_CR);
		send_item(CMD_TICK, 8'($urandom_range(0, 255)));
		send_item(CMD_BYTE, "A");
		send_item(CMD_BYTE, CH_CR);
		send_item(CMD_TICK, 8'($urandom_range(0, 255)));
		send_item(CMD_TICK, 8'($urandom_range(0, 255)));
	endtask

	// two ticks a step over 335 values; the receiver holds off at the start while ticks keep coming
	task automatic test_slow_ramp_under_hold();
		wait_reports_done();
		feed_steady = 1'b1;
		send_text("300 634 1");
		send_item(CMD_BYTE, CH_CR);
		hold_ask = 1'b1;
		tick_until_settled();
		feed_steady = 1'b0;
	endtask

	// mostly well-formed lines with random content, some noise and broken lines,
	// until the whole run has sent about the target number of items
	task automatic test_random_traffic();
		int unsigned pick;
		while (effective_items < ITEM_TARGET) begin
			feed_steady = ($urandom_range(0, 3) == 0);
			pick        = $urandom_range(0, 9);
			if (pick < 7) send_command_line(1'b0);
			else if (pick < 9) send_noise();
			else begin
				send_command_line(1'b1);
				send_noise();
			end
			if ($urandom_range(0, 24) == 0) wait_reports_done();
			if ($urandom_range(0, 59) == 0) hold_ask = 1'b1;
		end
	endtask

	// ---------------------------------------------------------------- main sequence

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		cmd         = CMD_BYTE;
		rx_byte     = 8'h00;
		hold_ask    = 1'b0;
		feed_steady = 1'b0;
		burst_left  = 0;
		mismatches  = 0;
		quiet_cycles = 0;
		effective_items = 0;
		clear_line();
		cur_duty   = '0;
		goal_duty  = '0;
		step_ticks = '0;
		ticks_left = '0;
		ramp_on    = 1'b0;
		ramp_down  = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_and_empty_line();
		test_saturated_set();
		test_short_ramp_with_drops();
		test_slow_ramp_under_hold();
		test_random_traffic();

		wait_reports_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_duty_reports.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/scpfr_pkg.sv
rtl/scpfr_front.sv
rtl/scpfr_queue.sv
rtl/scpfr_back.sv
rtl/serial_command_pwm_fade_ramp.sv
rtl/scpfr_checker.sv
tb/sv/serial_command_pwm_fade_ramp_test.sv
